// File: sv/kvrp_pkg.sv
package kvrp_pkg;

    // Parse phases; the error phases hold the sticky error.
    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_KLEN     = 4'd1,
        PH_DLEN     = 4'd2,
        PH_KEY      = 4'd3,
        PH_DASH     = 4'd4,
        PH_GT       = 4'd5,
        PH_DATA     = 4'd6,
        PH_NL       = 4'd7,
        PH_DONE     = 4'd8,
        PH_ERR_CHAR = 4'd9,
        PH_ERR_LEN  = 4'd10,
        PH_ERR_END  = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FRAME = 3'd0,
        KIND_KEY   = 3'd1,
        KIND_DATA  = 3'd2,
        KIND_REC   = 3'd3,
        KIND_DONE  = 3'd4,
        KIND_ERR   = 3'd5,
        KIND_IGN   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CHAR = 2'd1,
        ERR_LEN  = 2'd2,
        ERR_END  = 2'd3
    } err_t;

    // Classification of one transaction, passed from the parser core.
    typedef struct packed {
        kind_t kind;
        err_t  err;
    } ctrl_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic err_t phase_err(input phase_t ph);
        err_t e;
        e = ERR_NONE;
        unique case (ph)
            PH_ERR_CHAR: e = ERR_CHAR;
            PH_ERR_LEN:  e = ERR_LEN;
            PH_ERR_END:  e = ERR_END;
            default:     e = ERR_NONE;
        endcase
        return e;
    endfunction

endpackage

// File: sv/kvrp_core.sv
module kvrp_core
    import kvrp_pkg::*;
#(
    parameter int LENGTH_WIDTH     = 31,
    parameter int LINE_COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [7:0]                  in_byte,
    input  logic                        end_of_input,
    output ctrl_t                       res_ctrl,
    output logic [7:0]                  res_payload,
    output logic [LENGTH_WIDTH-1:0]     res_key_length,
    output logic [LENGTH_WIDTH-1:0]     res_data_length,
    output logic [LINE_COUNT_WIDTH-1:0] res_line_number
);

    localparam int LW = LENGTH_WIDTH;
    localparam int CW = LINE_COUNT_WIDTH;

    phase_t          phase_reg, phase_next;
    logic [LW-1:0]   acc_reg, acc_next;
    logic            seen_reg, seen_next;
    logic [LW-1:0]   hkey_reg, hkey_next;
    logic [LW-1:0]   hdata_reg, hdata_next;
    logic [LW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   line_reg, line_next;

    logic [3:0]      digit_full;
    logic [LW+3:0]   acc_sum;
    logic            is_digit;
    logic [7:0]      term;
    logic [LW-1:0]   rem_dec;

    // the low nibble of an ASCII digit is its value
    assign digit_full = in_byte[3:0];
    assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
    assign acc_sum    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {{LW{1'b0}}, digit_full};
    assign term       = (phase_reg == PH_KLEN) ? CH_COMMA : CH_COLON;
    assign rem_dec    = rem_reg - {{(LW-1){1'b0}}, 1'b1};

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        hkey_next       = hkey_reg;
        hdata_next      = hdata_reg;
        rem_next        = rem_reg;
        line_next       = line_reg;
        res_ctrl.kind   = KIND_FRAME;
        res_ctrl.err    = ERR_NONE;
        res_payload     = 8'd0;
        res_key_length  = '0;
        res_data_length = '0;

        if (phase_reg == PH_START && line_reg != {CW{1'b1}}) begin
            line_next = line_reg + {{(CW-1){1'b0}}, 1'b1};
        end

        unique case (phase_reg)
            PH_DONE: begin
                res_ctrl.kind = KIND_IGN;
            end
            PH_ERR_CHAR, PH_ERR_LEN, PH_ERR_END: begin
                res_ctrl.kind = KIND_ERR;
                res_ctrl.err  = phase_err(phase_reg);
            end
            default: begin
                if (end_of_input) begin
                    phase_next = PH_ERR_END;
                end else begin
                    unique case (phase_reg)
                        PH_START: begin
                            if (in_byte == CH_NL) begin
                                phase_next    = PH_DONE;
                                res_ctrl.kind = KIND_DONE;
                            end else if (in_byte == CH_PLUS) begin
                                acc_next   = '0;
                                seen_next  = 1'b0;
                                phase_next = PH_KLEN;
                            end else begin
                                phase_next = PH_ERR_CHAR;
                            end
                        end
                        PH_KLEN, PH_DLEN: begin
                            if (in_byte == term) begin
                                if (!seen_reg) begin
                                    phase_next = PH_ERR_CHAR;
                                end else begin
                                    acc_next  = '0;
                                    seen_next = 1'b0;
                                    if (phase_reg == PH_KLEN) begin
                                        hkey_next  = acc_reg;
                                        phase_next = PH_DLEN;
                                    end else begin
                                        hdata_next = acc_reg;
                                        rem_next   = hkey_reg;
                                        phase_next = (hkey_reg != '0) ? PH_KEY : PH_DASH;
                                    end
                                end
                            end else if (!is_digit) begin
                                phase_next = PH_ERR_CHAR;
                            end else if (acc_sum[LW+3:LW] != 4'd0) begin
                                phase_next = PH_ERR_LEN;
                            end else begin
                                acc_next  = acc_sum[LW-1:0];
                                seen_next = 1'b1;
                            end
                        end
                        PH_KEY: begin
                            rem_next      = rem_dec;
                            res_ctrl.kind = KIND_KEY;
                            res_payload   = in_byte;
                            if (rem_dec == '0) begin
                                phase_next = PH_DASH;
                            end
                        end
                        PH_DASH: begin
                            phase_next = (in_byte == CH_DASH) ? PH_GT : PH_ERR_CHAR;
                        end
                        PH_GT: begin
                            if (in_byte == CH_GT) begin
                                rem_next   = hdata_reg;
                                phase_next = (hdata_reg != '0) ? PH_DATA : PH_NL;
                            end else begin
                                phase_next = PH_ERR_CHAR;
                            end
                        end
                        PH_DATA: begin
                            rem_next      = rem_dec;
                            res_ctrl.kind = KIND_DATA;
                            res_payload   = in_byte;
                            if (rem_dec == '0) begin
                                phase_next = PH_NL;
                            end
                        end
                        PH_NL: begin
                            if (in_byte == CH_NL) begin
                                phase_next      = PH_START;
                                res_ctrl.kind   = KIND_REC;
                                res_key_length  = hkey_reg;
                                res_data_length = hdata_reg;
                            end else begin
                                phase_next = PH_ERR_CHAR;
                            end
                        end
                        default: begin
                            phase_next = PH_START;
                        end
                    endcase
                end
                // a fresh error reports on this transaction too
                if (phase_next == PH_ERR_CHAR || phase_next == PH_ERR_LEN
                    || phase_next == PH_ERR_END) begin
                    res_ctrl.kind = KIND_ERR;
                    res_ctrl.err  = phase_err(phase_next);
                end
            end
        endcase
        res_line_number = line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            hkey_reg  <= '0;
            hdata_reg <= '0;
            rem_reg   <= '0;
            line_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            hkey_reg  <= hkey_next;
            hdata_reg <= hdata_next;
            rem_reg   <= rem_next;
            line_reg  <= line_next;
        end
    end

endmodule

// File: sv/key_value_record_parser.sv
// Channel  | Dir | tdata (low bit up)                                   | tuser
// s_ input | in  | in_byte[7:0]                                         | end_of_input
// m_ out   | out | payload_byte, error_code, key_length, data_length,  | kind[2:0]
//          |     | line_number, zero fill to whole bytes                |
//
// One transaction is taken per cycle while m_tready does not stall; each input
// yields exactly one result, via an input register and then the parser core's
// single combinational pass into the result register. The parse state sits
// in the core and advances only when the input register moves into the result
// register. aresetn is synchronous, active low; it clears the phase, counters
// and valids. A stalled m_tready holds the result; an empty input register
// still fills, and s_tready drops while the input register holds a transaction.
module key_value_record_parser
    import kvrp_pkg::*;
#(
    parameter int LENGTH_WIDTH     = 31,
    parameter int LINE_COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // in_byte
    input  logic [0:0]             s_tuser,   // end_of_input
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // payload_byte, error_code, key_length, data_length, line_number
    output logic [((10 + 2*LENGTH_WIDTH + LINE_COUNT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [2:0]             m_tuser    // kind
);

    localparam int LW      = LENGTH_WIDTH;
    localparam int CW      = LINE_COUNT_WIDTH;
    localparam int USED_W  = 10 + 2*LW + CW;
    localparam int TDATA_W = ((USED_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - USED_W;

    // input register
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_eoi_reg;

    // result register
    logic          out_valid_reg;
    ctrl_t         out_ctrl_reg;
    logic [7:0]    out_payload_reg;
    logic [LW-1:0] out_klen_reg;
    logic [LW-1:0] out_dlen_reg;
    logic [CW-1:0] out_line_reg;

    ctrl_t         res_ctrl;
    logic [7:0]    res_payload;
    logic [LW-1:0] res_klen;
    logic [LW-1:0] res_dlen;
    logic [CW-1:0] res_line;

    logic          step_en;

    // advance when the result register is empty or being drained
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    kvrp_core #(
        .LENGTH_WIDTH     (LW),
        .LINE_COUNT_WIDTH (CW)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (step_en),
        .in_byte         (in_byte_reg),
        .end_of_input    (in_eoi_reg),
        .res_ctrl        (res_ctrl),
        .res_payload     (res_payload),
        .res_key_length  (res_klen),
        .res_data_length (res_dlen),
        .res_line_number (res_line)
    );

    // control: valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser[0];
        end
        if (step_en) begin
            out_ctrl_reg    <= res_ctrl;
            out_payload_reg <= res_payload;
            out_klen_reg    <= res_klen;
            out_dlen_reg    <= res_dlen;
            out_line_reg    <= res_line;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ctrl_reg.kind;
    assign m_tdata  = {{PAD_W{1'b0}}, out_line_reg, out_dlen_reg, out_klen_reg,
                       out_ctrl_reg.err, out_payload_reg};

endmodule

// File: tb/sv/kvrp_checker.sv
`timescale 1ns / 1ps

module kvrp_checker
    import kvrp_pkg::*;
#(
    parameter int LENGTH_WIDTH     = 31,
    parameter int LINE_COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,   // in_byte
    input  logic [0:0]             s_tuser,   // end_of_input
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // payload_byte, error_code, key_length, data_length, line_number
    input  logic [((10 + 2*LENGTH_WIDTH + LINE_COUNT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic [2:0]             m_tuser,   // kind
    output int                     pending,
    output int                     failures
);

    localparam int LW = LENGTH_WIDTH;
    localparam int CW = LINE_COUNT_WIDTH;
    localparam logic [LW+3:0] LEN_LIMIT = {4'b0, {LW{1'b1}}};

    typedef struct packed {
        kind_t           kind;
        logic [7:0]      payload;
        err_t            err;
        logic [LW-1:0]   key_len;
        logic [LW-1:0]   data_len;
        logic [CW-1:0]   line;
    } parse_tag_t;

    parse_tag_t     expected_tags[$];
    int             mismatch_count = 0;

    phase_t         phase;
    logic [LW-1:0]  number_acc;
    logic           digit_seen;
    logic [LW-1:0]  key_len_held;
    logic [LW-1:0]  data_len_held;
    logic [LW-1:0]  bytes_left;
    logic [CW-1:0]  line_cnt;

    assign failures = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Advance the parse state by one byte and return its classification.
    function automatic parse_tag_t classify_byte(input logic [7:0] c, input logic eoi);
        parse_tag_t    t;
        logic [7:0]    term;
        logic [LW+3:0] next;
        t = '{kind: KIND_FRAME, payload: 8'd0, err: ERR_NONE,
              key_len: '0, data_len: '0, line: '0};
        if (phase == PH_DONE) begin
            t.kind = KIND_IGN;
        end else if (phase < PH_ERR_CHAR) begin
            if (phase == PH_START && line_cnt != {CW{1'b1}})
                line_cnt = line_cnt + 1'b1;
            if (eoi) begin
                phase = PH_ERR_END;
            end else begin
                case (phase)
                    PH_START: begin
                        if (c == CH_NL) begin
                            phase  = PH_DONE;
                            t.kind = KIND_DONE;
                        end else if (c != CH_PLUS) begin
                            phase = PH_ERR_CHAR;
                        end else begin
                            number_acc = '0;
                            digit_seen = 1'b0;
                            phase      = PH_KLEN;
                        end
                    end
                    PH_KLEN, PH_DLEN: begin
                        term = (phase == PH_KLEN) ? CH_COMMA : CH_COLON;
                        if (c == term) begin
                            if (!digit_seen) begin
                                phase = PH_ERR_CHAR;
                            end else if (phase == PH_KLEN) begin
                                key_len_held = number_acc;
                                number_acc   = '0;
                                digit_seen   = 1'b0;
                                phase        = PH_DLEN;
                            end else begin
                                data_len_held = number_acc;
                                number_acc    = '0;
                                digit_seen    = 1'b0;
                                bytes_left    = key_len_held;
                                phase         = (bytes_left != 0) ? PH_KEY : PH_DASH;
                            end
                        end else if (c < CH_ZERO || c > CH_NINE) begin
                            phase = PH_ERR_CHAR;
                        end else begin
                            next = number_acc * 10 + (c - CH_ZERO);
                            if (next > LEN_LIMIT) begin
                                phase = PH_ERR_LEN;
                            end else begin
                                number_acc = next[LW-1:0];
                                digit_seen = 1'b1;
                            end
                        end
                    end
                    PH_KEY, PH_DATA: begin
                        t.kind    = (phase == PH_KEY) ? KIND_KEY : KIND_DATA;
                        t.payload = c;
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == 0)
                            phase = (phase == PH_KEY) ? PH_DASH : PH_NL;
                    end
                    PH_DASH: begin
                        phase = (c == CH_DASH) ? PH_GT : PH_ERR_CHAR;
                    end
                    PH_GT: begin
                        if (c != CH_GT) begin
                            phase = PH_ERR_CHAR;
                        end else begin
                            bytes_left = data_len_held;
                            phase      = (bytes_left != 0) ? PH_DATA : PH_NL;
                        end
                    end
                    default: begin
                        if (c != CH_NL) begin
                            phase = PH_ERR_CHAR;
                        end else begin
                            phase      = PH_START;
                            t.kind     = KIND_REC;
                            t.key_len  = key_len_held;
                            t.data_len = data_len_held;
                        end
                    end
                endcase
            end
        end
        // Fresh and sticky errors alike report from the held phase.
        case (phase)
            PH_ERR_CHAR: begin t.kind = KIND_ERR; t.err = ERR_CHAR; end
            PH_ERR_LEN:  begin t.kind = KIND_ERR; t.err = ERR_LEN;  end
            PH_ERR_END:  begin t.kind = KIND_ERR; t.err = ERR_END;  end
            default: ;
        endcase
        t.line = line_cnt;
        return t;
    endfunction

    task automatic check_result(input parse_tag_t want);
        if (m_tuser != want.kind)
            report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
        if (m_tdata[7:0] != want.payload)
            report_mismatch("payload_byte", 32'(m_tdata[7:0]), 32'(want.payload));
        if (m_tdata[9:8] != want.err)
            report_mismatch("error_code", 32'(m_tdata[9:8]), 32'(want.err));
        if (m_tdata[10 +: LW] != want.key_len)
            report_mismatch("key_length", 32'(m_tdata[10 +: LW]), 32'(want.key_len));
        if (m_tdata[10 + LW +: LW] != want.data_len)
            report_mismatch("data_length", 32'(m_tdata[10 + LW +: LW]),
                            32'(want.data_len));
        if (m_tdata[10 + 2*LW +: CW] != want.line)
            report_mismatch("line_number", 32'(m_tdata[10 + 2*LW +: CW]),
                            32'(want.line));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase         = PH_START;
            number_acc    = '0;
            digit_seen    = 1'b0;
            key_len_held  = '0;
            data_len_held = '0;
            bytes_left    = '0;
            line_cnt      = '0;
            expected_tags.delete();
            pending <= 0;
        end else begin
            // Compare before queuing: a result never belongs to a same-edge input.
            if (m_tvalid && m_tready) begin
                if (expected_tags.size() == 0)
                    report_mismatch("result with nothing expected", 32'(m_tuser), 0);
                else
                    check_result(expected_tags.pop_front());
            end
            if (s_tvalid && s_tready)
                expected_tags.push_back(classify_byte(s_tdata, s_tuser[0]));
            pending <= expected_tags.size();
        end
    end

endmodule

// File: tb/sv/tb_key_value_record_parser.sv
`timescale 1ns / 1ps

module tb_key_value_record_parser;
    import kvrp_pkg::*;

    localparam int LENGTH_WIDTH     = 31;
    localparam int LINE_COUNT_WIDTH = 32;
    localparam int TDATA_W = ((10 + 2*LENGTH_WIDTH + LINE_COUNT_WIDTH + 7) / 8) * 8;

    // Minimum number of stream bytes to build before the closing sequence.
    localparam int ITEM_TARGET = 850;
    // Cycle budget: roughly a hundred times the slowest legal run.
    localparam int CYCLE_LIMIT = 200000;

    // Handshake pressure phases, stepped through in order over the stream.
    localparam int MODE_STEADY      = 0;
    localparam int MODE_SEND_GAPS   = 1;
    localparam int MODE_RECV_STALLS = 2;
    localparam int MODE_BOTH        = 3;
    localparam int SINGLE_IDLE_PCT  = 57;
    localparam int BOTH_IDLE_PCT    = 31;

    // Ways the input can end; all but the first leave a sticky error.
    typedef enum int {
        END_DONE,
        END_EOI_AT_START,
        END_EOI_IN_RECORD,
        END_EMPTY_KEY_LEN,
        END_EMPTY_DATA_LEN,
        END_NON_DIGIT,
        END_BAD_DASH,
        END_BAD_NEWLINE,
        END_MAX_THEN_OVERFLOW,
        END_LONG_OVERFLOW,
        END_BAD_START,
        END_COUNT
    } ending_t;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
    } stream_item_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'd0;   // in_byte
    logic [0:0]         s_tuser  = 1'b0;   // end_of_input
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;           // payload_byte, error_code, key_length,
                                           // data_length, line_number
    logic [2:0]         m_tuser;           // kind

    int                 pending;
    int                 failures;
    int                 idle_mode = MODE_STEADY;
    int                 cycle_count = 0;
    stream_item_t       byte_stream[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    key_value_record_parser #(
        .LENGTH_WIDTH     (LENGTH_WIDTH),
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    kvrp_checker #(
        .LENGTH_WIDTH     (LENGTH_WIDTH),
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .pending  (pending),
        .failures (failures)
    );

    task automatic put_byte(input logic [7:0] b, input logic eoi);
        stream_item_t item;
        item.data = b;
        item.eoi  = eoi;
        byte_stream.push_back(item);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], 1'b0);
    endtask

    // Write a length in decimal, now and then with leading zeros.
    task automatic put_number(input int unsigned n);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) put_byte(CH_ZERO, 1'b0);
        put_text($sformatf("%0d", n));
    endtask

    // Key and data bytes: any value, biased toward ones that look like framing.
    function automatic logic [7:0] body_byte();
        string lookalikes;
        lookalikes = "+,:->\n09";
        if ($urandom_range(0, 4) == 0)
            return lookalikes[$urandom_range(0, lookalikes.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_record(input int unsigned klen, input int unsigned dlen);
        put_byte(CH_PLUS, 1'b0);
        put_number(klen);
        put_byte(CH_COMMA, 1'b0);
        put_number(dlen);
        put_byte(CH_COLON, 1'b0);
        repeat (klen) put_byte(body_byte(), 1'b0);
        put_byte(CH_DASH, 1'b0);
        put_byte(CH_GT, 1'b0);
        repeat (dlen) put_byte(body_byte(), 1'b0);
        put_byte(CH_NL, 1'b0);
    endtask

    function automatic int unsigned pick_length();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(0, 6);
    endfunction

    // Close the stream with one randomly chosen ending, then feed noise into
    // the parked parser to show the done or error state holds.
    task automatic put_ending();
        ending_t    ending;
        logic [7:0] b;
        ending = ending_t'($urandom_range(0, END_COUNT - 1));
        case (ending)
            END_DONE:          put_byte(CH_NL, 1'b0);
            END_EOI_AT_START:  put_byte(8'($urandom_range(0, 255)), 1'b1);
            END_EOI_IN_RECORD: begin
                put_text("+3,2:k");
                put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_EMPTY_KEY_LEN:  put_text("+,");
            END_EMPTY_DATA_LEN: put_text("+3,:");
            END_NON_DIGIT: begin
                put_text("+1");
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COMMA);
                put_byte(b, 1'b0);
            end
            END_BAD_DASH:          put_text("+1,0:k>");
            END_BAD_NEWLINE:       put_text("+0,1:->d+");
            END_MAX_THEN_OVERFLOW: put_text("+2147483647,2147483648");
            END_LONG_OVERFLOW:     put_text("+99999999999");
            default: begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_PLUS || b == CH_NL);
                put_byte(b, 1'b0);
            end
        endcase
        put_byte(8'($urandom_range(0, 255)), 1'b1);
        put_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (10) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    function automatic bit sender_idles();
        case (idle_mode)
            MODE_SEND_GAPS: return $urandom_range(0, 99) < SINGLE_IDLE_PCT;
            MODE_BOTH:      return $urandom_range(0, 99) < BOTH_IDLE_PCT;
            default:        return 1'b0;
        endcase
    endfunction

    // Receiver side: stall m_tready according to the current pressure phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (idle_mode)
                MODE_RECV_STALLS: m_tready <= $urandom_range(0, 99) >= SINGLE_IDLE_PCT;
                MODE_BOTH:        m_tready <= $urandom_range(0, 99) >= BOTH_IDLE_PCT;
                default:          m_tready <= 1'b1;
            endcase
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int idx;
        int total;
        int pause_at;
        bit paused;
        bit holding;

        // Directed: a record with both lengths zero, then one with a leading
        // zero, extreme byte values and a newline inside the data.
        put_text("+0,0:->\n");
        put_text("+01,2:");
        put_byte(8'hFF, 1'b0);
        put_byte(CH_DASH, 1'b0);
        put_byte(CH_GT, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(CH_NL, 1'b0);
        put_byte(CH_NL, 1'b0);

        // Random well-formed records; every malformed case is a terminal one
        // since errors stick until reset.
        while (byte_stream.size() < ITEM_TARGET)
            put_record(pick_length(), pick_length());
        put_ending();

        total    = byte_stream.size();
        pause_at = total / 3;
        paused   = 1'b0;
        holding  = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idx = 0;
        while (idx < total) begin
            // Drain once: hold off the sender until every result is back.
            if (idx == pause_at && !paused) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            idle_mode <= (idx * 4) / total;
            // Keep an offered transaction steady until it is taken.
            if (!holding) begin
                if (sender_idles()) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_stream[idx].data;
                    s_tuser  <= byte_stream[idx].eoi;
                end
            end
            @(posedge aclk);
            holding = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
                idx++;
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // Wait for the last results, then a few cycles for anything stray.
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
